// ----- design/charlieplex_twinkle_driver_top_assert.svh -----
// assertion macros used by the sequencer
`ifndef CHARLIEPLEX_TWINKLE_DRIVER_TOP_ASSERT_SVH
`define CHARLIEPLEX_TWINKLE_DRIVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CTD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CTD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ctd_pkg.sv -----
package ctd_pkg;

    localparam int NUM_POS = 10;
    localparam logic [4:0] LAST_SLOT = 5'd19;
    localparam logic [15:0] FPS_RESET = 16'd512;
    localparam logic [3:0] DIV_LAST = 4'd15;
    localparam logic [3:0] PH_LAST = 4'd9;

    typedef logic signed [3:0] phase_t;
    typedef logic [2:0] pin_t;

    localparam pin_t PIN_LO [NUM_POS] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
                                          3'd1, 3'd1, 3'd2, 3'd2, 3'd3};
    localparam pin_t PIN_HI [NUM_POS] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
                                          3'd3, 3'd4, 3'd3, 3'd4, 3'd4};
    localparam phase_t PHASE_INIT [NUM_POS] = '{4'sd3, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
                                                4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4};
    localparam logic [7:0] BRIGHT_TAB [5] = '{8'd0, 8'd35, 8'd99, 8'd195, 8'd255};

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } gen_t;

    localparam gen_t GEN_INIT = '{x: 8'd1, a: 8'd13, b: 8'd116, c: 8'd95};

    // sequencer steps
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PH
    } step_t;

    typedef enum logic {
        JC_DISPATCH,
        JC_COUNT
    } jcond_t;

    // one control word of the program
    typedef struct packed {
        logic       wait_item;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       div_en;
        logic       ph_en;
        jcond_t     jcond;
        logic [3:0] cnt_last;
        step_t      jump_a;
        step_t      jump_b;
        step_t      next_step;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic       tick;
        logic       reseed;
        logic       cfg;
        logic       div_en;
        logic       ph_en;
        logic [3:0] cnt;
    } ctd_ctl_t;

    typedef struct packed {
        logic [4:0] led;
        logic [4:0] lvl;
        logic [4:0] dir;
    } ctd_result_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            S_IDLE: w = '{wait_item: 1'b1, cnt_clr: 1'b1, cnt_inc: 1'b0, div_en: 1'b0,
                          ph_en: 1'b0, jcond: JC_DISPATCH, cnt_last: 4'd0,
                          jump_a: S_DIV, jump_b: S_PH, next_step: S_IDLE};
            S_DIV:  w = '{wait_item: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b1, div_en: 1'b1,
                          ph_en: 1'b0, jcond: JC_COUNT, cnt_last: DIV_LAST,
                          jump_a: S_IDLE, jump_b: S_IDLE, next_step: S_DIV};
            S_PH:   w = '{wait_item: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b1, div_en: 1'b0,
                          ph_en: 1'b1, jcond: JC_COUNT, cnt_last: PH_LAST,
                          jump_a: S_IDLE, jump_b: S_IDLE, next_step: S_PH};
            default: w = '{wait_item: 1'b0, cnt_clr: 1'b1, cnt_inc: 1'b0, div_en: 1'b0,
                           ph_en: 1'b0, jcond: JC_COUNT, cnt_last: 4'd0,
                           jump_a: S_IDLE, jump_b: S_IDLE, next_step: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic gen_t gen_round(gen_t g);
        gen_t r;
        r.x = g.x + 8'd1;
        r.a = g.a ^ g.c ^ r.x;
        r.b = g.b + r.a;
        r.c = (g.c + {1'b0, r.b[7:1]}) ^ r.a;
        return r;
    endfunction

    function automatic logic is_mult21(logic [7:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 12; k++)
        begin
            if (v == 8'(21 * k))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [7:0] brightness(phase_t p);
        logic [3:0] raw;
        logic [3:0] mag;
        raw = p;
        mag = raw[3] ? (~raw + 4'd1) : raw;
        return (mag > 4'd4) ? BRIGHT_TAB[4] : BRIGHT_TAB[mag[2:0]];
    endfunction

    function automatic phase_t phase_advance(phase_t p);
        phase_t r;
        if (p == -4'sd1)
        begin
            r = 4'sd0;
        end
        else if (p == 4'sd4)
        begin
            r = -4'sd3;
        end
        else
        begin
            r = p + 4'sd1;
        end
        return r;
    endfunction

endpackage

// ----- design/ctd_sequencer.sv -----
`include "charlieplex_twinkle_driver_top_assert.svh"

module ctd_sequencer
    import ctd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_op,
    input  logic     cfg_valid,
    input  logic     out_free,
    input  logic     due,
    output logic     s_tready,
    output logic     cfg_ready,
    output ctd_ctl_t ctl
);

    step_t      step_reg, step_next;
    logic [3:0] cnt_reg, cnt_next;
    ucode_t     word;
    logic       cfg_fire;
    logic       item_fire;

    assign word = ucode_rom(step_reg);

    // outputs decoded from the control word
    always_comb
    begin
        cfg_ready  = word.wait_item;
        s_tready   = word.wait_item & ~cfg_valid & out_free;
        cfg_fire   = cfg_valid & cfg_ready;
        item_fire  = s_tvalid & s_tready;
        ctl.tick   = item_fire & ~s_op;
        ctl.reseed = item_fire & s_op;
        ctl.cfg    = cfg_fire;
        ctl.div_en = word.div_en;
        ctl.ph_en  = word.ph_en;
        ctl.cnt    = cnt_reg;
    end

    // next step and loop count
    always_comb
    begin
        step_next = word.next_step;
        unique case (word.jcond)
            JC_DISPATCH:
            begin
                if (cfg_fire)
                begin
                    step_next = word.jump_a;
                end
                else if (ctl.tick && due)
                begin
                    step_next = word.jump_b;
                end
            end
            JC_COUNT:
            begin
                if (cnt_reg == word.cnt_last)
                begin
                    step_next = word.jump_a;
                end
            end
            default: step_next = S_IDLE;
        endcase

        if (word.cnt_clr)
        begin
            cnt_next = 4'd0;
        end
        else if (word.cnt_inc)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CTD_ASSERT_NOW(a_busy_blocks, clk, rst_n, step_reg != S_IDLE,
        !s_tready && !cfg_ready, "input or config taken while sequencer busy")
    `CTD_ASSERT_NOW(a_one_fire, clk, rst_n, cfg_fire, !item_fire,
        "config and item transfer in the same cycle")
    `CTD_ASSERT_NEXT(a_ph_start, clk, rst_n, ctl.tick && due && !cfg_fire,
        step_reg == S_PH && cnt_reg == 4'd0, "phase walk did not start at position zero")
    `CTD_ASSERT_NEXT(a_ph_end, clk, rst_n, step_reg == S_PH && cnt_reg == PH_LAST,
        step_reg == S_IDLE, "phase walk did not return to idle")
    `CTD_ASSERT_NEXT(a_div_start, clk, rst_n, cfg_fire,
        step_reg == S_DIV && cnt_reg == 4'd0, "remainder recompute did not start")

endmodule

// ----- design/ctd_datapath.sv -----
module ctd_datapath
    import ctd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctd_ctl_t    ctl,
    input  logic [7:0]  entropy_a,
    input  logic [7:0]  entropy_b,
    input  logic [7:0]  entropy_c,
    input  logic [15:0] cfg_data,
    output logic        due,
    output ctd_result_t result
);

    logic [4:0]  slot_reg, slot_next;
    logic [7:0]  pwm_reg, pwm_next;
    logic [15:0] frame_reg, frame_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] fps_reg, fps_next;
    phase_t      phase_reg [NUM_POS];
    phase_t      phase_next [NUM_POS];
    gen_t        gen_reg, gen_next;

    logic [3:0]  pos;
    pin_t        lo, hi;
    logic [16:0] period;
    logic [16:0] rem_inc;
    logic        wrap_hit;
    logic [16:0] div_try;
    gen_t        round_in, round_out;
    phase_t      p0;
    logic        draw;
    logic        adv;

    // slot output
    always_comb
    begin
        pos = slot_reg[4:1];
        lo  = PIN_LO[pos];
        hi  = PIN_HI[pos];
        result.led = slot_reg;
        result.dir = (5'd1 << lo) | (5'd1 << hi);
        if (pwm_reg < brightness(phase_reg[pos]))
        begin
            result.lvl = 5'd1 << (slot_reg[0] ? hi : lo);
        end
        else
        begin
            result.lvl = 5'd0;
        end
    end

    // frame_count modulo interval, kept incrementally
    always_comb
    begin
        period   = (fps_reg == 16'd0) ? 17'h10000 : {1'b0, fps_reg};
        rem_inc  = {1'b0, rem_reg} + 17'd1;
        wrap_hit = (frame_reg == 16'hFFFF) || (rem_inc == period);
        due      = (slot_reg == LAST_SLOT) && wrap_hit;
        div_try  = {rem_reg, frame_reg[~ctl.cnt]};
    end

    // shared generator round
    always_comb
    begin
        if (ctl.reseed)
        begin
            round_in = '{x: gen_reg.x, a: gen_reg.a ^ entropy_a,
                         b: gen_reg.b ^ entropy_b, c: gen_reg.c ^ entropy_c};
        end
        else
        begin
            round_in = gen_reg;
        end
        round_out = gen_round(round_in);
        p0   = phase_reg[0];
        draw = (p0 == 4'sd0) || (p0 == 4'sd4);
        adv  = !draw || is_mult21(round_out.c);
    end

    always_comb
    begin
        slot_next  = slot_reg;
        pwm_next   = pwm_reg;
        frame_next = frame_reg;
        rem_next   = rem_reg;
        fps_next   = fps_reg;
        gen_next   = gen_reg;
        phase_next = phase_reg;

        if (ctl.cfg)
        begin
            fps_next = cfg_data;
            rem_next = 16'd0;
        end

        // restoring division step, msb first
        if (ctl.div_en)
        begin
            if (div_try >= period)
            begin
                rem_next = 16'(div_try - period);
            end
            else
            begin
                rem_next = div_try[15:0];
            end
        end

        if (ctl.tick)
        begin
            if (slot_reg == LAST_SLOT)
            begin
                slot_next  = 5'd0;
                pwm_next   = pwm_reg + 8'd1;
                frame_next = frame_reg + 16'd1;
                rem_next   = wrap_hit ? 16'd0 : rem_inc[15:0];
            end
            else
            begin
                slot_next = slot_reg + 5'd1;
            end
        end

        if (ctl.reseed)
        begin
            gen_next = round_out;
        end

        // phase ring rotates one place per step, back in order after a walk over all positions
        if (ctl.ph_en)
        begin
            for (int i = 0; i < NUM_POS - 1; i++)
            begin
                phase_next[i] = phase_reg[i + 1];
            end
            phase_next[NUM_POS - 1] = adv ? phase_advance(p0) : p0;
            if (draw)
            begin
                gen_next = round_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 5'd0;
            pwm_reg   <= 8'd0;
            frame_reg <= 16'd0;
            rem_reg   <= 16'd0;
            fps_reg   <= FPS_RESET;
            gen_reg   <= GEN_INIT;
            phase_reg <= PHASE_INIT;
        end
        else
        begin
            slot_reg  <= slot_next;
            pwm_reg   <= pwm_next;
            frame_reg <= frame_next;
            rem_reg   <= rem_next;
            fps_reg   <= fps_next;
            gen_reg   <= gen_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- design/charlieplex_twinkle_driver_top.sv -----
// a tick transfer writes its result into the output register
// throughput: one item per cycle while the output register is free; a frame end that
//   steps the phases holds the input while the phase ring turns, one position per cycle
// a config write holds the input during the bit-serial remainder of the frame count
// reset: asynchronous, active low; all state but the output payload returns to its initial values at once
module charlieplex_twinkle_driver_top
    import ctd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // tick / reseed stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // entropy_a [7:0], entropy_b [15:8], entropy_c [23:16]
    input  logic        s_tuser,   // op: 0 tick one led slot, 1 reseed generator
    // pin result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pin_direction [4:0], pin_level [9:5],
                                   // led_shown [14:10], zero [15]
    // frames_per_step register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    ctd_ctl_t    ctl;
    ctd_result_t result;
    logic        due;
    logic        out_free;

    // output register decouples the result side from the sequencer
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;

    // a new tick may transfer when the slot is empty or drains this cycle
    assign out_free = ~m_valid_reg | m_tready;

    // microcoded control: step counter, loop counter, handshakes
    ctd_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_op      (s_tuser),
        .cfg_valid (cfg_valid),
        .out_free  (out_free),
        .due       (due),
        .s_tready  (s_tready),
        .cfg_ready (cfg_ready),
        .ctl       (ctl)
    );

    // slot/pwm/frame counters, phase ring, generator, divider
    ctd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .entropy_a (s_tdata[7:0]),
        .entropy_b (s_tdata[15:8]),
        .entropy_c (s_tdata[23:16]),
        .cfg_data  (cfg_data),
        .due       (due),
        .result    (result)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctl.tick)
        begin
            // capture the pin pattern of the slot being shown
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, result.led, result.lvl, result.dir};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
